[rtl/pfb_pkg.sv]
// Package for the pixel format to BGRA8 converter.
// Holds the format codes, lane input struct and scaling constants; no dependencies.
`default_nettype none

package pfb_pkg;

    typedef enum logic [1:0] {
        FMT_BGRA8   = 2'd0,
        FMT_RGBA8   = 2'd1,
        FMT_RGB10A2 = 2'd2,
        FMT_RGBA16F = 2'd3
    } t_fmt;

    localparam int NUM_LANES = 4;

    // floor(x*255/1023) == (x * SCALE10_MUL) >> SCALE10_SHIFT for x < 1024
    localparam logic [23:0] SCALE10_MUL   = 24'd8364085;
    localparam int          SCALE10_SHIFT = 25;
    localparam int          SCALE10_PRODW = 34;

    localparam logic [4:0] HALF_EXP_SPECIAL = 5'h1F;
    localparam logic [4:0] HALF_EXP_ONE     = 5'd15;
    localparam logic [4:0] HALF_SHIFT_SUB   = 5'd24;
    localparam logic [4:0] HALF_SHIFT_BASE  = 5'd25;
    localparam logic [7:0] HALF_SCALE       = 8'd255;
    localparam logic [7:0] BYTE_MAX         = 8'hFF;

    typedef struct packed {
        logic [7:0]  byte_val;
        logic [9:0]  unorm;
        logic [15:0] half;
    } t_lane_in;

endpackage

`default_nettype wire

[rtl/pfb_if.sv]
// Request channel interfaces for the pixel format converter.
// Source pixel channel and BGRA8 result channel; no dependencies.
`default_nettype none

interface pfb_pix_if;
    logic        valid;
    logic        ready;
    logic [63:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

interface pfb_bgra_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;

    modport source (output valid, output blue, output green, output red, output alpha,
                    input ready);
    modport sink   (input valid, input blue, input green, input red, input alpha,
                    output ready);
endinterface

`default_nettype wire

[rtl/pixel_format_to_bgra8.sv]
// Top level of the pixel format to BGRA8 converter.
// Uses pfb_pkg, pfb_if, pfb_lane and pfb_merge.
//
//  channel   dir  payload                   handshake
//  i_pix     in   pixel_word[63:0]          valid/ready
//  o_bgra    out  blue, green, red, alpha   valid/ready
//  i_cfg_*   in   source_format[1:0]        write enable, no ready
//
// One pixel per clock while the output is not held: products register in
// the lanes, then the merge stage registers the ordered bytes.
// Both stages advance together whenever the output register is empty or taken.
// Synchronous active-low reset clears the valid bits and the format register.
`default_nettype none

module pixel_format_to_bgra8 (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    pfb_pix_if.sink         i_pix,
    pfb_bgra_if.source      o_bgra
);

    pfb_pkg::t_fmt     r_fmt;
    pfb_pkg::t_fmt     r_fmt_s1;
    logic              r_vld_s1;
    logic              r_vld_s2;
    logic              adv;
    pfb_pkg::t_lane_in lane_in   [pfb_pkg::NUM_LANES];
    logic [7:0]        lane_byte [pfb_pkg::NUM_LANES];
    logic [63:0]       w;

    assign w           = i_pix.pixel_word;
    assign adv         = !r_vld_s2 || o_bgra.ready;
    assign i_pix.ready = adv;
    assign o_bgra.valid = r_vld_s2;

    always_comb begin
        for (int k = 0; k < pfb_pkg::NUM_LANES; k++) begin
            lane_in[k].byte_val = w[8*k +: 8];
            lane_in[k].half     = w[16*k +: 16];
            lane_in[k].unorm    = 10'd0;
        end
        lane_in[0].unorm = w[9:0];
        lane_in[1].unorm = w[19:10];
        lane_in[2].unorm = w[29:20];
        lane_in[3].unorm = {5{w[31:30]}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= pfb_pkg::FMT_BGRA8;
            r_fmt_s1 <= pfb_pkg::FMT_BGRA8;
            r_vld_s1 <= 1'b0;
            r_vld_s2 <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= pfb_pkg::t_fmt'(i_cfg_wdata);
            end
            if (adv) begin
                r_fmt_s1 <= r_fmt;
                r_vld_s1 <= i_pix.valid;
                r_vld_s2 <= r_vld_s1;
            end
        end
    end

    for (genvar g = 0; g < pfb_pkg::NUM_LANES; g++) begin : g_lane
        pfb_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (adv),
            .i_lane   (lane_in[g]),
            .i_fmt_s1 (r_fmt_s1),
            .o_byte   (lane_byte[g])
        );
    end

    pfb_merge u_merge (
        .i_clk       (i_clk),
        .i_en        (adv),
        .i_fmt_s1    (r_fmt_s1),
        .i_lane_byte (lane_byte),
        .o_blue      (o_bgra.blue),
        .o_green     (o_bgra.green),
        .o_red       (o_bgra.red),
        .o_alpha     (o_bgra.alpha)
    );

endmodule

`default_nettype wire

[rtl/pfb_lane.sv]
// One conversion lane: turns one source channel into a byte for the current format.
// Uses pfb_pkg; registers the products, finishes shift and select after the register.
`default_nettype none

module pfb_lane (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire pfb_pkg::t_lane_in i_lane,
    input  wire pfb_pkg::t_fmt   i_fmt_s1,
    output logic [7:0]           o_byte
);

    logic                                  half_sign;
    logic [4:0]                            half_exp;
    logic [9:0]                            half_man;
    logic [10:0]                           half_sig;
    logic [18:0]                           n_hprod;
    logic [4:0]                            n_hshift;
    logic                                  n_hzero;
    logic                                  n_hsat;
    logic [pfb_pkg::SCALE10_PRODW-1:0]     prod10;

    logic [7:0]  r_byte;
    logic [7:0]  r_q10;
    logic [18:0] r_hprod;
    logic [4:0]  r_hshift;
    logic        r_hzero;
    logic        r_hsat;
    logic [18:0] hshifted;
    logic [7:0]  half_byte;

    assign half_sign = i_lane.half[15];
    assign half_exp  = i_lane.half[14:10];
    assign half_man  = i_lane.half[9:0];

    always_comb begin
        prod10   = pfb_pkg::SCALE10_PRODW'(i_lane.unorm) *
                   pfb_pkg::SCALE10_PRODW'(pfb_pkg::SCALE10_MUL);
        half_sig = (half_exp == 5'd0) ? {1'b0, half_man} : {1'b1, half_man};
        n_hprod  = 19'(half_sig) * 19'(pfb_pkg::HALF_SCALE);
        n_hshift = (half_exp == 5'd0) ? pfb_pkg::HALF_SHIFT_SUB
                                      : pfb_pkg::HALF_SHIFT_BASE - half_exp;
        n_hzero  = half_sign || ((half_exp == pfb_pkg::HALF_EXP_SPECIAL) && (half_man != 10'd0));
        n_hsat   = !half_sign && (half_exp >= pfb_pkg::HALF_EXP_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte   <= i_lane.byte_val;
            r_q10    <= prod10[pfb_pkg::SCALE10_SHIFT +: 8];
            r_hprod  <= n_hprod;
            r_hshift <= n_hshift;
            r_hzero  <= n_hzero;
            r_hsat   <= n_hsat;
        end
    end

    always_comb begin
        hshifted = r_hprod >> r_hshift;
        if (r_hzero) begin
            half_byte = 8'd0;
        end else if (r_hsat) begin
            half_byte = pfb_pkg::BYTE_MAX;
        end else begin
            half_byte = hshifted[7:0];
        end
        case (i_fmt_s1)
            pfb_pkg::FMT_BGRA8:   o_byte = r_byte;
            pfb_pkg::FMT_RGBA8:   o_byte = r_byte;
            pfb_pkg::FMT_RGB10A2: o_byte = r_q10;
            pfb_pkg::FMT_RGBA16F: o_byte = half_byte;
            default:              o_byte = r_byte;
        endcase
    end

endmodule

`default_nettype wire

[rtl/pfb_merge.sv]
// Merge stage: orders the four lane bytes into blue, green, red, alpha and registers them.
// Uses pfb_pkg; fed by four pfb_lane instances.
`default_nettype none

module pfb_merge (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire pfb_pkg::t_fmt i_fmt_s1,
    input  wire logic [7:0]    i_lane_byte [pfb_pkg::NUM_LANES],
    output logic [7:0]         o_blue,
    output logic [7:0]         o_green,
    output logic [7:0]         o_red,
    output logic [7:0]         o_alpha
);

    logic [7:0] n_blue;
    logic [7:0] n_red;

    always_comb begin
        if (i_fmt_s1 == pfb_pkg::FMT_BGRA8) begin
            n_blue = i_lane_byte[0];
            n_red  = i_lane_byte[2];
        end else begin
            n_blue = i_lane_byte[2];
            n_red  = i_lane_byte[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_blue  <= n_blue;
            o_green <= i_lane_byte[1];
            o_red   <= n_red;
            o_alpha <= i_lane_byte[3];
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_pixel_format_to_bgra8.sv]
// Self-checking testbench for pixel_format_to_bgra8: drives pixel requests and
// format writes, predicts BGRA8 bytes per format and checks every result in order.
// Depends on pfb_pkg, pfb_if and the pixel_format_to_bgra8 RTL.
module tb_pixel_format_to_bgra8;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } t_bgra;

    class bgra_scoreboard;
        pfb_pkg::t_fmt fmt;
        t_bgra         expected_q[$];
        int            fail_count;

        function new();
            fmt        = pfb_pkg::FMT_BGRA8;
            fail_count = 0;
        endfunction

        function logic [7:0] unorm10_to_8(logic [9:0] x);
            int unsigned q;
            q = (32'(x) * 32'd255) / 32'd1023;
            return q[7:0];
        endfunction

        function logic [7:0] half_to_unorm8(logic [15:0] h);
            logic [4:0]  ex;
            logic [9:0]  man;
            int unsigned sig;
            int unsigned sh;
            int unsigned q;
            ex  = h[14:10];
            man = h[9:0];
            if (ex == 5'h1F) return (man != 10'd0 || h[15]) ? 8'h00 : 8'hFF;
            if (h[15]) return 8'h00;
            if (ex >= 5'd15) return 8'hFF;
            if (ex == 5'd0) begin
                sig = 32'(man);
                sh  = 24;
            end else begin
                sig = 32'(man) + 32'h400;
                sh  = 25 - 32'(ex);
            end
            q = (sig * 32'd255) >> sh;
            return q[7:0];
        endfunction

        function t_bgra convert_pixel(logic [63:0] w);
            t_bgra       px;
            int unsigned a2;
            case (fmt)
                pfb_pkg::FMT_BGRA8: begin
                    px.blue  = w[7:0];
                    px.green = w[15:8];
                    px.red   = w[23:16];
                    px.alpha = w[31:24];
                end
                pfb_pkg::FMT_RGBA8: begin
                    px.red   = w[7:0];
                    px.green = w[15:8];
                    px.blue  = w[23:16];
                    px.alpha = w[31:24];
                end
                pfb_pkg::FMT_RGB10A2: begin
                    px.red   = unorm10_to_8(w[9:0]);
                    px.green = unorm10_to_8(w[19:10]);
                    px.blue  = unorm10_to_8(w[29:20]);
                    a2       = (32'(w[31:30]) * 32'd255) / 32'd3;
                    px.alpha = a2[7:0];
                end
                default: begin
                    px.red   = half_to_unorm8(w[15:0]);
                    px.green = half_to_unorm8(w[31:16]);
                    px.blue  = half_to_unorm8(w[47:32]);
                    px.alpha = half_to_unorm8(w[63:48]);
                end
            endcase
            return px;
        endfunction

        function void note_request(logic [63:0] w);
            expected_q.push_back(convert_pixel(w));
        endfunction

        function void check_result(t_bgra got);
            t_bgra want;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result b=%02h g=%02h r=%02h a=%02h",
                             got.blue, got.green, got.red, got.alpha);
                return;
            end
            want = expected_q.pop_front();
            if (got.blue !== want.blue || got.green !== want.green ||
                got.red !== want.red || got.alpha !== want.alpha) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"mismatch %s: expected b=%02h g=%02h r=%02h a=%02h,",
                              " got b=%02h g=%02h r=%02h a=%02h"},
                             fmt.name(), want.blue, want.green, want.red, want.alpha,
                             got.blue, got.green, got.red, got.alpha);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_wdata;
    bit          stall_on;
    int unsigned gap_pct;

    pfb_pix_if  pix();
    pfb_bgra_if bgra();

    bgra_scoreboard sb;

    pixel_format_to_bgra8 uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix),
        .o_bgra      (bgra)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix.valid && pix.ready)
            sb.note_request(pix.pixel_word);
        if (i_rst_n && bgra.valid && bgra.ready)
            sb.check_result({bgra.blue, bgra.green, bgra.red, bgra.alpha});
    end

    initial begin
        bgra.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            bgra.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (stall_on && $urandom_range(0, 1) == 1) begin
                bgra.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [9:0] rand_unorm10();
        case ($urandom_range(0, 5))
            0:       return 10'h000;
            1:       return 10'h3FF;
            default: return 10'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_half();
        logic       s;
        logic [4:0] e;
        logic [9:0] m;
        s = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 7))
            0:       e = 5'h1F;
            1:       e = 5'h00;
            2:       e = 5'($urandom_range(15, 30));
            default: e = 5'($urandom_range(1, 14));
        endcase
        case ($urandom_range(0, 5))
            0:       m = 10'h000;
            1:       m = 10'h3FF;
            default: m = 10'($urandom);
        endcase
        return {s, e, m};
    endfunction

    function automatic logic [63:0] rand_pixel(pfb_pkg::t_fmt f);
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 7) != 0) begin
            case (f)
                pfb_pkg::FMT_RGB10A2:
                    w[29:0] = {rand_unorm10(), rand_unorm10(), rand_unorm10()};
                pfb_pkg::FMT_RGBA16F:
                    w = {rand_half(), rand_half(), rand_half(), rand_half()};
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic send_pixel(input logic [63:0] word);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        pix.valid      <= 1'b1;
        pix.pixel_word <= word;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
    endtask

    task automatic set_format(input pfb_pkg::t_fmt f);
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= f;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.fmt   = f;
    endtask

    task automatic send_directed(input pfb_pkg::t_fmt f);
        case (f)
            pfb_pkg::FMT_BGRA8, pfb_pkg::FMT_RGBA8: begin
                send_pixel(64'h0);
                send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
                send_pixel(64'hA5C3_0F96_0123_4567);
            end
            pfb_pkg::FMT_RGB10A2: begin
                send_pixel(64'h0);
                send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
                send_pixel({32'hFFFF_FFFF, 2'd1, 10'h001, 10'h3FE, 10'h200});
                send_pixel({32'h0, 2'd2, 10'h3FF, 10'h000, 10'h3FF});
            end
            default: begin
                // zero, negative zero, smallest and largest subnormal
                send_pixel({16'h0000, 16'h8000, 16'h0001, 16'h03FF});
                // smallest normal, just below one, one, largest finite
                send_pixel({16'h0400, 16'h3BFF, 16'h3C00, 16'h7BFF});
                // infinities and NaNs of both signs
                send_pixel({16'h7C00, 16'hFC00, 16'h7E00, 16'hFE01});
                send_pixel({16'hBC00, 16'h7C01, 16'h3800, 16'h2C00});
                send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
            end
        endcase
    endtask

    task automatic run_phase(input pfb_pkg::t_fmt f, input int unsigned count,
                             input bit directed);
        set_format(f);
        if (directed) send_directed(f);
        repeat (count) send_pixel(rand_pixel(f));
        pix.valid <= 1'b0;
    endtask

    initial begin
        sb             = new();
        pix.valid      = 1'b0;
        pix.pixel_word = 64'h0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = pfb_pkg::FMT_BGRA8;
        i_rst_n        = 1'b0;
        stall_on       = 1'b1;
        gap_pct        = 20;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(pfb_pkg::FMT_BGRA8, 100, 1'b1);
        run_phase(pfb_pkg::FMT_RGBA8, 100, 1'b1);
        run_phase(pfb_pkg::FMT_RGB10A2, 100, 1'b1);
        run_phase(pfb_pkg::FMT_RGBA16F, 100, 1'b1);
        for (int p = 0; p < 10; p++) begin
            if (p == 9) begin
                stall_on = 1'b0;
                gap_pct  = 0;
            end else begin
                stall_on = ($urandom_range(0, 3) != 0);
                gap_pct  = stall_on ? $urandom_range(5, 40) : 0;
            end
            run_phase(pfb_pkg::t_fmt'($urandom_range(0, 3)), 120, 1'b0);
        end

        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
